// ===== rtl/kdlp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kdlp_pkg: shared types and constants for the key debouncer
// request and event codes, register indexes and reset values
// ---------------------------------------------------------------------------
package kdlp_pkg;

  localparam int NUM_KEYS_DEF   = 4;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int REQ_W     = 2;
  localparam int PIN_W     = 4;
  localparam int NOW_W     = 32;
  localparam int KEY_IDX_W = 2;
  localparam int OUT_W     = 4;
  localparam int EV_W      = 2;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic            ACTIVE_LOW_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_FETCH = 2'd2
  } req_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 2'd0,
    EV_CLICK    = 2'd1,
    EV_LONG     = 2'd2,
    EV_LONG_REL = 2'd3
  } ev_e;

  // per-key command for the word being processed
  typedef struct packed {
    logic init;
    logic scan;
    logic clr;
  } key_ctl_t;

endpackage

// ===== rtl/key_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_debounce_long_press: multi-key debouncer with long-press detection
// input register, per-key update logic and a result register
// ---------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  request | in_valid_i, in_stall_o, req_type_i, pin_levels_i, | in
//          | now_ms_i, key_index_i                            |
//  result  | out_valid_o, out_stall_i, stable_pressed_o,       | out
//          | event_code_o                                     |
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i                   | in
//
// one word per cycle while the result side does not stall; a taken request word
// is held in the input register, then loads the result register, where it is taken.
// a stalled result holds both stages; in_stall_o rises only while both
// stages are full and the result side stalls.
// reset clears all key state and loads the register defaults.
module key_debounce_long_press #(
  parameter int NUM_KEYS   = kdlp_pkg::NUM_KEYS_DEF,
  parameter int TIME_WIDTH = kdlp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdlp_pkg::REQ_W-1:0]     req_type_i,
  input  logic [kdlp_pkg::PIN_W-1:0]     pin_levels_i,
  input  logic [kdlp_pkg::NOW_W-1:0]     now_ms_i,
  input  logic [kdlp_pkg::KEY_IDX_W-1:0] key_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdlp_pkg::OUT_W-1:0]     stable_pressed_o,
  output logic [kdlp_pkg::EV_W-1:0]      event_code_o,
  input  logic                          cfg_we_i,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kdlp_pkg::*;

  // configuration registers
  logic [MS_W-1:0] debounce_q;
  logic [MS_W-1:0] long_press_q;
  logic            active_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
      active_low_q <= ACTIVE_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i[MS_W-1:0];
        CFG_LONG_PRESS: long_press_q <= cfg_data_i[MS_W-1:0];
        CFG_ACTIVE_LOW: active_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake between the stages
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_ready;
  logic s1_ready;
  logic go;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign go         = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;

  // input register
  logic [REQ_W-1:0]     req_q;
  logic [PIN_W-1:0]     pins_q;
  logic [NOW_W-1:0]     now_q;
  logic [KEY_IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      req_q  <= req_type_i;
      pins_q <= pin_levels_i;
      now_q  <= now_ms_i;
      idx_q  <= key_index_i;
    end
  end

  // request decode
  logic                  is_init, is_scan, is_fetch;
  logic [TIME_WIDTH-1:0] now_t;

  always_comb begin
    is_init  = 1'b0;
    is_scan  = 1'b0;
    is_fetch = 1'b0;
    case (req_e'(req_q))
      REQ_INIT:  is_init  = go;
      REQ_SCAN:  is_scan  = go;
      REQ_FETCH: is_fetch = go;
      default: ;
    endcase
  end

  assign now_t = TIME_WIDTH'(now_q);

  // key lanes
  logic [NUM_KEYS-1:0] stable_nxt;
  ev_e                 key_ev [NUM_KEYS];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    key_ctl_t ctl;
    logic     raw;

    // keys without a pin see level 0
    if (k < PIN_W) begin : g_pin
      assign raw = pins_q[k] ^ active_low_q;
    end else begin : g_nopin
      assign raw = active_low_q;
    end

    assign ctl.init = is_init;
    assign ctl.scan = is_scan;
    assign ctl.clr  = is_fetch && (int'(idx_q) == k);

    kdlp_key #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_key (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .raw_i        (raw),
      .now_i        (now_t),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .stable_nxt_o (stable_nxt[k]),
      .event_o      (key_ev[k])
    );
  end

  // result word
  logic [OUT_W-1:0] stable_bits;
  logic [EV_W-1:0]  fetch_ev;

  always_comb begin
    stable_bits = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k < OUT_W) begin
        stable_bits[k] = stable_nxt[k];
      end
    end
  end

  always_comb begin
    fetch_ev = EV_NONE;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (is_fetch && (int'(idx_q) == k)) begin
        fetch_ev = key_ev[k];
      end
    end
  end

  logic [OUT_W-1:0] stable_pressed_q;
  logic [EV_W-1:0]  event_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      stable_pressed_q <= stable_bits;
      event_code_q     <= fetch_ev;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stable_pressed_o = stable_pressed_q;
  assign event_code_o     = event_code_q;

  // checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_o)
    else $error("processed word produced no result");

  a_event_fetch_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && !is_fetch) |=> (event_code_o == EV_NONE))
    else $error("event reported for a non-fetch request");

endmodule

// ===== rtl/kdlp_key.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kdlp_key: state and update logic of one key
// debounce, press timing, click, long-press and long-release event latch
// ---------------------------------------------------------------------------
module kdlp_key #(
  parameter int TIME_WIDTH = kdlp_pkg::TIME_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kdlp_pkg::key_ctl_t       ctl_i,
  input  logic                     raw_i,
  input  logic [TIME_WIDTH-1:0]    now_i,
  input  logic [kdlp_pkg::MS_W-1:0] debounce_i,
  input  logic [kdlp_pkg::MS_W-1:0] long_press_i,
  output logic                     stable_nxt_o,
  output kdlp_pkg::ev_e            event_o
);
  import kdlp_pkg::*;

  logic                  stable_q, stable_d;
  logic                  last_q, last_d;
  logic                  fired_q, fired_d;
  logic [TIME_WIDTH-1:0] chg_q, chg_d;
  logic [TIME_WIDTH-1:0] press_q, press_d;
  ev_e                   pend_q, pend_d;

  logic [TIME_WIDTH-1:0] deb_age;
  logic [TIME_WIDTH-1:0] hold_age;

  always_comb begin
    stable_d = stable_q;
    last_d   = last_q;
    fired_d  = fired_q;
    chg_d    = chg_q;
    press_d  = press_q;
    pend_d   = pend_q;
    deb_age  = now_i - chg_q;
    hold_age = now_i - press_q;
    if (ctl_i.init) begin
      stable_d = raw_i;
      last_d   = raw_i;
      fired_d  = 1'b0;
      chg_d    = now_i;
      press_d  = now_i;
      pend_d   = EV_NONE;
    end else if (ctl_i.scan) begin
      if (raw_i != last_q) begin
        last_d = raw_i;
        chg_d  = now_i;
      end
      deb_age = now_i - chg_d;
      if ((deb_age >= TIME_WIDTH'(debounce_i)) && (raw_i != stable_q)) begin
        stable_d = raw_i;
        if (raw_i) begin
          press_d = now_i;
        end else begin
          pend_d = fired_q ? EV_LONG_REL : EV_CLICK;
        end
        fired_d = 1'b0;
      end
      hold_age = now_i - press_d;
      if (stable_d && !fired_d && (hold_age >= TIME_WIDTH'(long_press_i))) begin
        fired_d = 1'b1;
        pend_d  = EV_LONG;
      end
    end else if (ctl_i.clr) begin
      pend_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      last_q   <= 1'b0;
      fired_q  <= 1'b0;
      chg_q    <= '0;
      press_q  <= '0;
      pend_q   <= EV_NONE;
    end else begin
      stable_q <= stable_d;
      last_q   <= last_d;
      fired_q  <= fired_d;
      chg_q    <= chg_d;
      press_q  <= press_d;
      pend_q   <= pend_d;
    end
  end

  assign stable_nxt_o = stable_d;
  assign event_o      = pend_q;

endmodule
